// File: design/sbit_pkg.sv
// shared types and constants for the sorted breakpoint interpolation table
package sbit_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RIDX_W      = 6;
  localparam int RCNT_W      = 7;
  localparam int MUL_STEPS   = 33;
  localparam int DIV_STEPS   = 64;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  localparam logic [31:0] Q_MINUS_ONE = 32'hFFFF_0000;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SET   = 2'd1,
    OP_EVAL  = 2'd2,
    OP_CLEAR = 2'd3
  } sbit_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } sbit_status_e;

  typedef enum logic [2:0] {
    RES_CLEAR  = 3'd0,
    RES_EMPTY  = 3'd1,
    RES_FULL   = 3'd2,
    RES_INS    = 3'd3,
    RES_UPD    = 3'd4,
    RES_CUR    = 3'd5,
    RES_PREV   = 3'd6,
    RES_INTERP = 3'd7
  } sbit_res_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } sbit_point_t;

  typedef struct packed {
    logic      accept;
    logic      clear;
    logic      idx_inc;
    logic      idx_dec;
    logic      idx_to_count;
    logic      save_prev;
    logic      set_pos;
    logic      rd_shift;
    logic      wr_upd;
    logic      wr_shift;
    logic      wr_new;
    logic      md_start;
    logic      res_load;
    sbit_res_e res_sel;
    logic      out_load;
  } sbit_cmd_t;

  typedef struct packed {
    sbit_op_e in_op;
    sbit_op_e op;
    logic     idx_at_count;
    logic     idx_at_pos;
    logic     idx_zero;
    logic     cur_ge;
    logic     cur_eq;
    logic     full;
    logic     empty;
    logic     md_done;
    logic     out_free;
  } sbit_stat_t;

endpackage

// File: design/sbit_if.sv
// input and result channel interfaces
interface sbit_in_if;
  import sbit_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_value;
  modport source (output valid, output opcode, output x_coord, output y_value, input ready);
  modport sink   (input valid, input opcode, input x_coord, input y_value, output ready);
endinterface

interface sbit_out_if;
  import sbit_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [31:0]  result_y;
  logic [RIDX_W-1:0]   result_index;
  logic [RCNT_W-1:0]   entry_count;
  logic [1:0]          status;
  modport source (output valid, output result_y, output result_index, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input result_y, input result_index, input entry_count,
                  input status, output ready);
endinterface

// File: design/sbit_ram.sv
// generic single write, single read ram with registered read data
module sbit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: design/sbit_muldiv.sv
// serial shift-add multiplier followed by a restoring divider
module sbit_muldiv import sbit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] mag_i,
  input  logic [32:0] mult_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [32:0] quot_o
);
  logic              busy_q, busy_d;
  logic              div_q, div_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       mcand_q, mcand_d;
  logic [32:0]       mplier_q, mplier_d;
  logic [32:0]       dvs_q, dvs_d;
  logic [32:0]       rem_q, rem_d;
  logic [33:0]       rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, acc_q[63]};
  assign fits   = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d   = busy_q;
    div_d    = div_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    if (start_i) begin
      busy_d   = 1'b1;
      div_d    = 1'b0;
      cnt_d    = STEP_W'(MUL_STEPS);
      acc_d    = '0;
      mcand_d  = {31'd0, mag_i};
      mplier_d = mult_i;
      dvs_d    = divisor_i;
    end else if (busy_q && !div_q) begin
      if (cnt_q == '0) begin
        div_d = 1'b1;
        cnt_d = STEP_W'(DIV_STEPS);
        rem_d = '0;
      end else begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[62:0], 1'b0};
        mplier_d = {1'b0, mplier_q[32:1]};
        cnt_d    = cnt_q - STEP_W'(1);
      end
    end else if (busy_q) begin
      // dividend shifts out of acc while quotient bits shift in
      rem_d = fits ? 33'(rem_sh - {1'b0, dvs_q}) : rem_sh[32:0];
      acc_d = {acc_q[62:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    dvs_q    <= dvs_d;
    rem_q    <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q[32:0];
endmodule

// File: design/sbit_datapath.sv
// table storage, scan index, result and output registers
module sbit_datapath import sbit_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbit_cmd_t          cmd_i,
  output sbit_stat_t         stat_o,
  input  logic [1:0]         in_opcode_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_y_o,
  output logic [RIDX_W-1:0]  out_idx_o,
  output logic [RCNT_W-1:0]  out_count_o,
  output logic [1:0]         out_status_o
);
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   idx_m1;
  logic [IDX_W-1:0]   pos_q;
  sbit_op_e           op_q;
  logic signed [31:0] qx_q, qy_q;
  sbit_point_t        prev_q, cur;
  logic               neg_q;
  logic signed [31:0] base_y_q;
  logic signed [31:0] res_y_q;
  logic [IDX_W-1:0]   res_idx_q;
  sbit_status_e       res_st_q;
  logic               out_valid_q;
  logic signed [31:0] out_y_q;
  logic [RIDX_W-1:0]  out_idx_q;
  logic [RCNT_W-1:0]  out_count_q;
  sbit_status_e       out_st_q;

  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [63:0]        wdata, rdata;

  logic [32:0]        sum, dy, dx, span, mag;
  logic signed [31:0] new_y, interp_y;
  logic               md_done;
  logic [32:0]        quot;

  sbit_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cur    = sbit_point_t'(rdata);
  assign idx_m1 = idx_q - CNT_W'(1);
  assign raddr  = cmd_i.rd_shift ? idx_m1[IDX_W-1:0] : idx_q[IDX_W-1:0];

  // averaging on a 33-bit sum, arithmetic shift
  assign sum   = {cur.y[31], cur.y} + {qy_q[31], qy_q};
  assign new_y = (op_q == OP_ADD) ? sum[32:1] : qy_q;

  assign dy   = {cur.y[31], cur.y} - {prev_q.y[31], prev_q.y};
  assign dx   = {qx_q[31], qx_q} - {prev_q.x[31], prev_q.x};
  assign span = {cur.x[31], cur.x} - {prev_q.x[31], prev_q.x};
  assign mag  = dy[32] ? 33'(-dy) : dy;

  sbit_muldiv u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.md_start),
    .mag_i     (mag),
    .mult_i    (dx),
    .divisor_i (span),
    .done_o    (md_done),
    .quot_o    (quot)
  );

  assign interp_y = base_y_q + (neg_q ? -quot[31:0] : quot[31:0]);

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[IDX_W-1:0];
    wdata = {cur.x, new_y};
    if (cmd_i.wr_upd) begin
      we = 1'b1;
    end else if (cmd_i.wr_shift) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (cmd_i.wr_new) begin
      we    = 1'b1;
      waddr = pos_q;
      wdata = {qx_q, qy_q};
    end
  end

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.wr_new) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.accept) begin
      idx_d = '0;
    end else if (cmd_i.idx_to_count) begin
      idx_d = count_q;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CNT_W'(1);
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.accept) begin
      op_q <= sbit_op_e'(in_opcode_i);
      qx_q <= in_x_i;
      qy_q <= in_y_i;
    end
    if (cmd_i.save_prev) begin
      prev_q <= cur;
    end
    if (cmd_i.set_pos) begin
      pos_q <= idx_q[IDX_W-1:0];
    end
    if (cmd_i.md_start) begin
      neg_q    <= dy[32];
      base_y_q <= prev_q.y;
    end
    if (cmd_i.res_load) begin
      res_idx_q <= '0;
      res_st_q  <= ST_OK;
      res_y_q   <= '0;
      case (cmd_i.res_sel)
        RES_CLEAR: ;
        RES_EMPTY: begin
          res_y_q  <= Q_MINUS_ONE;
          res_st_q <= ST_EMPTY;
        end
        RES_FULL:  res_st_q <= ST_FULL;
        RES_INS: begin
          res_y_q   <= qy_q;
          res_idx_q <= pos_q;
        end
        RES_UPD: begin
          res_y_q   <= new_y;
          res_idx_q <= idx_q[IDX_W-1:0];
        end
        RES_CUR:    res_y_q <= cur.y;
        RES_PREV:   res_y_q <= prev_q.y;
        RES_INTERP: res_y_q <= interp_y;
        default:    res_y_q <= '0;
      endcase
    end
    if (cmd_i.out_load) begin
      out_y_q     <= res_y_q;
      out_idx_q   <= RIDX_W'(res_idx_q);
      out_count_q <= RCNT_W'(count_q);
      out_st_q    <= res_st_q;
    end
  end

  assign stat_o.in_op        = sbit_op_e'(in_opcode_i);
  assign stat_o.op           = op_q;
  assign stat_o.idx_at_count = idx_q == count_q;
  assign stat_o.idx_at_pos   = idx_q == CNT_W'(pos_q);
  assign stat_o.idx_zero     = idx_q == '0;
  assign stat_o.cur_ge       = cur.x >= qx_q;
  assign stat_o.cur_eq       = cur.x == qx_q;
  assign stat_o.full         = count_q == CNT_W'(TABLE_DEPTH);
  assign stat_o.empty        = count_q == '0;
  assign stat_o.md_done      = md_done;
  assign stat_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_y_o      = out_y_q;
  assign out_idx_o    = out_idx_q;
  assign out_count_o  = out_count_q;
  assign out_status_o = out_st_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_no_insert_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> !stat_o.full)
    else $error("insert into full table");

  a_out_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");
endmodule

// File: design/sbit_ctrl.sv
// sequencing of scan, insert shift, update and interpolation
module sbit_ctrl import sbit_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sbit_stat_t stat_i,
  output sbit_cmd_t  cmd_o
);
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CHK = 8'b0000_0100,
    S_SH_RD    = 8'b0000_1000,
    S_SH_WR    = 8'b0001_0000,
    S_INS      = 8'b0010_0000,
    S_MULDIV   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } sbit_state_e;

  sbit_state_e state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.in_op == OP_CLEAR) begin
            cmd_o.clear    = 1'b1;
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_CLEAR;
            state_d        = S_DONE;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (stat_i.idx_at_count) begin
          // query lies past every stored point
          if (stat_i.op == OP_EVAL) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = stat_i.empty ? RES_EMPTY : RES_PREV;
            state_d        = S_DONE;
          end else if (stat_i.full) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_FULL;
            state_d        = S_DONE;
          end else begin
            cmd_o.set_pos      = 1'b1;
            cmd_o.idx_to_count = 1'b1;
            state_d            = S_SH_RD;
          end
        end else begin
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.cur_ge) begin
          if (stat_i.op == OP_EVAL) begin
            if (stat_i.cur_eq || stat_i.idx_zero) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_sel  = RES_CUR;
              state_d        = S_DONE;
            end else begin
              cmd_o.md_start = 1'b1;
              state_d        = S_MULDIV;
            end
          end else if (stat_i.cur_eq) begin
            cmd_o.wr_upd   = 1'b1;
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_UPD;
            state_d        = S_DONE;
          end else if (stat_i.full) begin
            cmd_o.res_load = 1'b1;
            cmd_o.res_sel  = RES_FULL;
            state_d        = S_DONE;
          end else begin
            cmd_o.set_pos      = 1'b1;
            cmd_o.idx_to_count = 1'b1;
            state_d            = S_SH_RD;
          end
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        if (stat_i.idx_at_pos) begin
          state_d = S_INS;
        end else begin
          cmd_o.rd_shift = 1'b1;
          state_d        = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_dec  = 1'b1;
        state_d        = S_SH_RD;
      end
      S_INS: begin
        cmd_o.wr_new   = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RES_INS;
        state_d        = S_DONE;
      end
      S_MULDIV: begin
        if (stat_i.md_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_INTERP;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: design/sorted_breakpoint_interpolation_table_top.sv
// Sorted breakpoint table in signed Q16.16 with piecewise-linear evaluation. One
// transaction is taken at a time and gives one result. A lookup scans the table
// through a single registered-read RAM port, one entry at a time with a read state
// and a check state per entry passed; inserting moves every later entry up one
// place, with a read state and a write state each; an update writes in place.
// Interpolation then adds a serial multiply and a restoring divide. On an insert,
// scan and shift together cover every entry once. The next item is accepted while
// a result waits to be taken. Table contents are undefined after reset and need no
// clearing pass; of the table state only the entry count is reset.
module sorted_breakpoint_interpolation_table_top import sbit_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  sbit_in_if.sink   in_i,
  sbit_out_if.source out_o
);
  sbit_cmd_t  cmd;
  sbit_stat_t stat;

  sbit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sbit_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_opcode_i  (in_i.opcode),
    .in_x_i       (in_i.x_coord),
    .in_y_i       (in_i.y_value),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_y_o      (out_o.result_y),
    .out_idx_o    (out_o.result_index),
    .out_count_o  (out_o.entry_count),
    .out_status_o (out_o.status)
  );
endmodule

// File: sim/tb_top.sv
// testbench for the sorted breakpoint interpolation table: directed table, a fill-to-full pass, then random traffic
`timescale 1ns / 100ps

module tb_top;
  import sbit_pkg::*;

  localparam int LIMIT = 2000000;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit                 typed;
    logic signed [31:0] ey;
    logic [5:0]         eidx;
    logic [6:0]         ecnt;
    logic [1:0]         est;
  } row_t;

  typedef struct {
    logic signed [31:0] y;
    logic [5:0]         idx;
    logic [6:0]         cnt;
    logic [1:0]         st;
  } lookup_res_t;

  logic clk_i;
  logic rst_ni;
  sbit_in_if  in_ch();
  sbit_out_if out_ch();

  sorted_breakpoint_interpolation_table_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // local copy of the table
  logic signed [31:0] tbl_x [TABLE_DEPTH];
  logic signed [31:0] tbl_y [TABLE_DEPTH];
  int                 tbl_n;

  lookup_res_t pending_q[$];
  int          errors;
  int          cycles;
  bit          out_stall_on;

  initial begin
    clk_i = 1'b0;
    forever begin
      #4 clk_i = 1'b1;
      #4 clk_i = 1'b0;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  function automatic lookup_res_t table_step(logic [1:0] op, logic signed [31:0] x,
                                             logic signed [31:0] y);
    lookup_res_t r;
    int pos, nx;
    logic signed [32:0] sum;
    logic signed [63:0] dy, dx, span;
    logic [63:0] mag;
    r = '{y: '0, idx: '0, cnt: '0, st: ST_OK};
    pos = -1;
    if (op == OP_ADD || op == OP_SET) begin
      for (int i = 0; i < tbl_n; i++) if (pos < 0 && tbl_x[i] == x) pos = i;
      if (pos >= 0) begin
        if (op == OP_ADD) begin
          sum = 33'(tbl_y[pos]) + 33'(y);
          tbl_y[pos] = 32'(sum >>> 1);
        end else tbl_y[pos] = y;
        r.y = tbl_y[pos];
        r.idx = 6'(pos);
      end else if (tbl_n >= TABLE_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        pos = 0;
        while (pos < tbl_n && tbl_x[pos] < x) pos++;
        for (int i = tbl_n; i > pos; i--) begin
          tbl_x[i] = tbl_x[i-1];
          tbl_y[i] = tbl_y[i-1];
        end
        tbl_x[pos] = x;
        tbl_y[pos] = y;
        tbl_n++;
        r.y = y;
        r.idx = 6'(pos);
      end
    end else if (op == OP_EVAL) begin
      if (tbl_n == 0) begin
        r.y = Q_MINUS_ONE;
        r.st = ST_EMPTY;
      end else if (x <= tbl_x[0]) r.y = tbl_y[0];
      else if (x >= tbl_x[tbl_n-1]) r.y = tbl_y[tbl_n-1];
      else begin
        nx = 1;
        while (nx < tbl_n && tbl_x[nx] < x) nx++;
        if (tbl_x[nx] == x) r.y = tbl_y[nx];
        else begin
          dy = 64'(tbl_y[nx]) - 64'(tbl_y[nx-1]);
          dx = 64'(x) - 64'(tbl_x[nx-1]);
          span = 64'(tbl_x[nx]) - 64'(tbl_x[nx-1]);
          mag = ((dy < 0) ? 64'(-dy) : 64'(dy)) * 64'(dx);
          mag = mag / 64'(span);
          r.y = 32'(64'(tbl_y[nx-1]) + ((dy < 0) ? -$signed(mag) : $signed(mag)));
        end
      end
    end else tbl_n = 0;
    r.cnt = 7'(tbl_n);
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.x_coord <= x;
    in_ch.y_value <= y;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_q.push_back(table_step(op, x, y));
  endtask

  // result side with random stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result y=%h", $time, out_ch.result_y);
          errors++;
        end else begin
          lookup_res_t e;
          e = pending_q.pop_front();
          if (e.y !== out_ch.result_y || e.idx !== out_ch.result_index ||
              e.cnt !== out_ch.entry_count || e.st !== out_ch.status) begin
            $display("%0t mismatch exp y=%h idx=%0d cnt=%0d st=%0d act y=%h idx=%0d cnt=%0d st=%0d",
                     $time, e.y, e.idx, e.cnt, e.st, out_ch.result_y, out_ch.result_index,
                     out_ch.entry_count, out_ch.status);
            errors++;
          end
        end
      end
      out_ch.ready <= out_stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial out_stall_on = 1'b0;
  always @(posedge clk_i) if ($urandom_range(0, 299) == 0) out_stall_on <= !out_stall_on;

  row_t dir_rows[$];

  function automatic row_t mk(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y);
    row_t r;
    r.op = op; r.x = x; r.y = y; r.typed = 0;
    r.ey = 0; r.eidx = 0; r.ecnt = 0; r.est = ST_OK;
    return r;
  endfunction

  function automatic row_t mkt(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] ey, logic [5:0] ei, logic [6:0] ec,
                               logic [1:0] es);
    row_t r;
    r = mk(op, x, y);
    r.typed = 1; r.ey = ey; r.eidx = ei; r.ecnt = ec; r.est = es;
    return r;
  endfunction

  initial begin
    int n_rand, k, mode;
    logic [1:0] op;
    logic signed [31:0] x, y;
    errors = 0;
    cycles = 0;
    tbl_n = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.x_coord = '0;
    in_ch.y_value = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extremes, exact hits, averaging with odd negative sum, clamps
    dir_rows.push_back(mkt(OP_EVAL, 32'sh0, 32'sh0, Q_MINUS_ONE, 0, 0, ST_EMPTY));
    dir_rows.push_back(mkt(OP_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1, ST_OK));
    dir_rows.push_back(mkt(OP_EVAL, 32'sh1234, 32'sh0, 32'sh7FFF_FFFF, 0, 1, ST_OK));
    dir_rows.push_back(mkt(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1, 2, ST_OK));
    dir_rows.push_back(mk(OP_EVAL, 32'sh0, 32'sh0));
    dir_rows.push_back(mk(OP_EVAL, 32'sh7FFF_FFFE, 32'sh0));
    dir_rows.push_back(mk(OP_EVAL, 32'sh8000_0001, 32'sh0));
    dir_rows.push_back(mk(OP_ADD, 32'sh0001_0000, 32'sh0002_0000));
    dir_rows.push_back(mk(OP_ADD, 32'sh0001_0000, 32'shFFFF_FFFF));
    dir_rows.push_back(mk(OP_ADD, 32'sh0001_0000, 32'sh8000_0000));
    dir_rows.push_back(mk(OP_SET, 32'sh0001_0000, 32'shFFFF_0000));
    dir_rows.push_back(mk(OP_SET, 32'sh0003_0000, 32'sh0005_0000));
    dir_rows.push_back(mk(OP_EVAL, 32'sh0002_0000, 32'sh0));
    dir_rows.push_back(mk(OP_EVAL, 32'sh0001_0000, 32'sh0));
    dir_rows.push_back(mk(OP_EVAL, 32'sh0000_8000, 32'sh0));
    dir_rows.push_back(mk(OP_EVAL, 32'sh7FFF_FFFF, 32'sh0));
    dir_rows.push_back(mk(OP_EVAL, 32'sh8000_0000, 32'sh0));
    dir_rows.push_back(mkt(OP_CLEAR, 32'sh5555_5555, 32'shAAAA_AAAA, 0, 0, 0, ST_OK));
    dir_rows.push_back(mkt(OP_EVAL, 32'sh0, 32'sh0, Q_MINUS_ONE, 0, 0, ST_EMPTY));
    dir_rows.push_back(mk(OP_SET, 32'sh0, 32'sh0));

    foreach (dir_rows[i]) begin
      lookup_res_t pr;
      send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y);
      if (dir_rows[i].typed) begin
        pr = pending_q[$];
        if (pr.y !== dir_rows[i].ey || pr.idx !== dir_rows[i].eidx ||
            pr.cnt !== dir_rows[i].ecnt || pr.st !== dir_rows[i].est) begin
          $display("%0t table row %0d exp y=%h act y=%h", $time, i, dir_rows[i].ey, pr.y);
          errors++;
        end
      end
    end

    // fill to full, then refused inserts and lookups on the full table
    send_item(OP_CLEAR, 32'sh0, 32'sh0);
    for (k = 0; k < TABLE_DEPTH; k++)
      send_item(OP_SET, 32'($urandom_range(0, 63)) <<< 20 ^ 32'(k), $urandom());
    for (k = 0; k < 4; k++) send_item(OP_ADD, $urandom(), $urandom());
    for (k = 0; k < 20; k++) send_item(OP_EVAL, $urandom(), $urandom());
    send_item(OP_CLEAR, 32'sh0, 32'sh0);

    // random: mostly small tables with mixed inserts, updates and queries, sometimes wide values
    n_rand = 0;
    while (n_rand < 640) begin
      mode = $urandom_range(0, 99);
      if (mode < 3) op = OP_CLEAR;
      else if (mode < 30) op = OP_ADD;
      else if (mode < 50) op = OP_SET;
      else op = OP_EVAL;
      if (op != OP_EVAL && tbl_n > 12 && $urandom_range(0, 3) == 0) op = OP_CLEAR;
      if ($urandom_range(0, 3) == 0) x = $urandom();
      else if (tbl_n > 0 && $urandom_range(0, 2) == 0)
        x = tbl_x[$urandom_range(0, tbl_n - 1)];
      else x = $signed(32'($urandom_range(0, 32))) - 16 <<< $urandom_range(0, 24);
      y = ($urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 255)) - 128) <<< 12);
      send_item(op, x, y);
      n_rand++;
    end
    in_ch.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
